// ----- hw/rtl/fcr_pkg.sv -----
// Shared types and constants for the framed command receiver.
// Holds the item structs, status codes and the byte-wide CRC-16 update.
// No dependencies.
package fcr_pkg;

  localparam int unsigned CountW = 8;

  localparam logic [15:0] FrameHeader = 16'hFFFF;
  localparam logic [15:0] CrcInit     = 16'hFFFF;
  localparam logic [15:0] CrcPoly     = 16'hA001;
  localparam logic [CountW-1:0] MinFrameBytes = CountW'(4);
  localparam logic [CountW-1:0] HeaderBytes   = CountW'(2);

  // Meaning of req_type
  typedef enum logic {
    REQ_DATA = 1'b0,
    REQ_IDLE = 1'b1
  } fcr_req_kind_t;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_HEADER = 2'd1,
    STATUS_TOO_SHORT  = 2'd2,
    STATUS_CRC_ERROR  = 2'd3
  } fcr_status_t;

  typedef struct packed {
    fcr_req_kind_t req_type;
    logic [7:0]    rx_byte;
  } fcr_req_t;

  typedef struct packed {
    fcr_status_t frame_status;
    logic [15:0] command_word;
    logic [31:0] value_word;
    logic [15:0] mode_word;
  } fcr_rsp_t;

  // Control from the frame collector to the CRC unit
  typedef struct packed {
    logic clear;   // frame ended, back to initial state
    logic shift;   // a kept byte enters the delay line
    logic fold;    // the byte leaving the delay line goes into the CRC
  } fcr_crc_ctl_t;

  // Modbus CRC-16, one byte, reflected polynomial
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/fcr_crc_unit.sv -----
// CRC-16 accumulator behind a two-byte delay line.
// The last two bytes of a frame stay in the delay line and never enter the CRC.
// Depends on fcr_pkg.
module fcr_crc_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  fcr_pkg::fcr_crc_ctl_t ctl,
  input  logic [7:0]           rx_byte,
  output logic [15:0]          crc_accum,
  output logic [15:0]          tail_delay
);
  import fcr_pkg::*;

  logic [15:0] crc_accum_next;

  // CRC of the byte leaving the delay line
  always_comb begin
    crc_accum_next = crc_accum;
    if (ctl.fold) begin
      crc_accum_next = crc16_byte(crc_accum, tail_delay[15:8]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      crc_accum  <= CrcInit;
      tail_delay <= 16'h0000;
    end else if (ctl.shift) begin
      crc_accum  <= crc_accum_next;
      tail_delay <= {tail_delay[7:0], rx_byte};
    end
  end

endmodule

// ----- hw/rtl/framed_command_receiver_crc16.sv -----
// Framed command receiver with Modbus CRC-16 check. Takes one item per clock:
// a data byte, or a line-idle mark that closes the frame. Each idle item yields
// one result in the next cycle (frame status plus command, value and mode words);
// data bytes yield none. The only stall is a result held in the output register
// while rsp_ready is low: then req_ready drops. Throughput is one item per cycle,
// set by the single-byte CRC update between the CRC register and itself.
// Bytes past MAX_FRAME_BYTES are dropped. Depends on fcr_pkg and fcr_crc_unit.
module framed_command_receiver_crc16 #(
  parameter int unsigned MAX_FRAME_BYTES = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  fcr_pkg::fcr_req_t req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output fcr_pkg::fcr_rsp_t rsp
);
  import fcr_pkg::*;

  logic [CountW-1:0] byte_count;
  logic [15:0]       header_seen;
  logic [15:0]       command_hold;
  logic [31:0]       value_hold;
  logic [15:0]       mode_hold;
  logic [15:0]       crc_accum;
  logic [15:0]       tail_delay;

  logic         accept;
  logic         data_acc;
  logic         idle_acc;
  logic         keep_byte;
  fcr_crc_ctl_t crc_ctl;
  fcr_status_t  status;
  fcr_rsp_t     rsp_next;

  // Handshake: a held, untaken result blocks the next item
  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign data_acc  = accept && (req.req_type == REQ_DATA);
  assign idle_acc  = accept && (req.req_type == REQ_IDLE);
  assign keep_byte = data_acc && (byte_count < CountW'(MAX_FRAME_BYTES));

  assign crc_ctl.clear = idle_acc;
  assign crc_ctl.shift = keep_byte;
  assign crc_ctl.fold  = keep_byte && (byte_count >= MinFrameBytes);

  fcr_crc_unit u_crc (
    .clk        (clk),
    .rst        (rst),
    .ctl        (crc_ctl),
    .rx_byte    (req.rx_byte),
    .crc_accum  (crc_accum),
    .tail_delay (tail_delay)
  );

  // Frame check, in priority order
  always_comb begin
    if (header_seen != FrameHeader || byte_count < HeaderBytes) begin
      status = STATUS_BAD_HEADER;
    end else if (byte_count < MinFrameBytes) begin
      status = STATUS_TOO_SHORT;
    end else if ({crc_accum[7:0], crc_accum[15:8]} != tail_delay) begin
      status = STATUS_CRC_ERROR;
    end else begin
      status = STATUS_OK;
    end
  end

  always_comb begin
    rsp_next.frame_status = status;
    rsp_next.command_word = command_hold;
    rsp_next.value_word   = value_hold;
    rsp_next.mode_word    = mode_hold;
  end

  // Byte collection: count and field capture
  always_ff @(posedge clk) begin
    if (rst || idle_acc) begin
      byte_count   <= '0;
      header_seen  <= 16'h0000;
      command_hold <= 16'h0000;
      value_hold   <= 32'h0000_0000;
      mode_hold    <= 16'h0000;
    end else if (keep_byte) begin
      byte_count <= byte_count + CountW'(1);
      case (byte_count)
        CountW'(0): header_seen[15:8]  <= req.rx_byte;
        CountW'(1): header_seen[7:0]   <= req.rx_byte;
        CountW'(2): command_hold[15:8] <= req.rx_byte;
        CountW'(3): command_hold[7:0]  <= req.rx_byte;
        CountW'(4): value_hold[31:24]  <= req.rx_byte;
        CountW'(5): value_hold[23:16]  <= req.rx_byte;
        CountW'(6): value_hold[15:8]   <= req.rx_byte;
        CountW'(7): value_hold[7:0]    <= req.rx_byte;
        CountW'(8): mode_hold[15:8]    <= req.rx_byte;
        CountW'(9): mode_hold[7:0]     <= req.rx_byte;
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (idle_acc) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (idle_acc) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ----- hw/rtl/fcr_check.sv -----
// Port-level checks for the framed command receiver, bound to the top level.
// Depends on fcr_pkg and framed_command_receiver_crc16.
module fcr_check (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input fcr_pkg::fcr_req_t req,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input fcr_pkg::fcr_rsp_t rsp
);
  import fcr_pkg::*;

  logic idle_acc;
  assign idle_acc = req_valid && req_ready && (req.req_type == REQ_IDLE);

  // A stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // Every idle item gives a result next cycle
  a_idle_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    idle_acc |=> rsp_valid)
    else $error("idle item gave no result");

  // A new result only follows an idle item
  a_rsp_from_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(idle_acc))
    else $error("result without idle item");

  // A taken result is not repeated
  a_rsp_drains: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ready && !idle_acc |=> !rsp_valid)
    else $error("result repeated");

endmodule

bind framed_command_receiver_crc16 fcr_check u_fcr_check (.*);
